>>> design/tfn_pkg.sv
// Shared types and constants for the triangle face normal block.
package tfn_pkg;

   localparam int QUEUE_DEPTH = 8;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic              empty;
      logic [QLVL_W-1:0] level;
   } tfn_qstat_type;

endpackage

>>> design/tfn_front.sv
// Front end: edges, cross product terms, sign/magnitude split and degenerate flag.
module tfn_front #(
   parameter int COORD_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [COORD_BITS-1:0]           req_ax,
   input  logic signed [COORD_BITS-1:0]           req_ay,
   input  logic signed [COORD_BITS-1:0]           req_az,
   input  logic signed [COORD_BITS-1:0]           req_bx,
   input  logic signed [COORD_BITS-1:0]           req_by_coord,
   input  logic signed [COORD_BITS-1:0]           req_bz,
   input  logic signed [COORD_BITS-1:0]           req_cx,
   input  logic signed [COORD_BITS-1:0]           req_cy,
   input  logic signed [COORD_BITS-1:0]           req_cz,
   input  logic                                   req_last_triangle,
   input  tfn_pkg::tfn_qstat_type                 qstat,
   output logic                                   push,
   output logic [3*(2*COORD_BITS+2)+4:0]          push_item
);
   import tfn_pkg::*;

   localparam int EW = COORD_BITS + 1;
   localparam int PW = 2 * EW;
   localparam int MW = 2 * COORD_BITS + 2;

   logic signed [COORD_BITS-1:0] va [3];
   logic signed [COORD_BITS-1:0] vb [3];
   logic signed [COORD_BITS-1:0] vc [3];

   logic                v1_ff, v2_ff, v3_ff;
   logic                l1_ff, l2_ff, l3_ff;
   logic signed [EW-1:0] e1_ff [3];
   logic signed [EW-1:0] e2_ff [3];
   logic signed [PW-1:0] pa_ff [3];
   logic signed [PW-1:0] pb_ff [3];
   logic [MW-1:0]        mag_ff [3];
   logic [2:0]           neg_ff;
   logic [MW-1:0]        mag_in [3];
   logic [2:0]           neg_in;
   logic signed [PW:0]   diff [3];
   logic [QLVL_W:0]      occupancy;
   logic                 accept;

   assign va[0] = req_ax;
   assign va[1] = req_ay;
   assign va[2] = req_az;
   assign vb[0] = req_bx;
   assign vb[1] = req_by_coord;
   assign vb[2] = req_bz;
   assign vc[0] = req_cx;
   assign vc[1] = req_cy;
   assign vc[2] = req_cz;

   // count everything in flight toward the queue so a push always finds room
   assign occupancy = {1'b0, qstat.level} + (QLVL_W+1)'(v1_ff) + (QLVL_W+1)'(v2_ff)
                    + (QLVL_W+1)'(v3_ff);
   assign req_stall = occupancy >= (QLVL_W+1)'(QUEUE_DEPTH);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         diff[i]   = {pa_ff[i][PW-1], pa_ff[i]} - {pb_ff[i][PW-1], pb_ff[i]};
         neg_in[i] = diff[i][PW];
         mag_in[i] = neg_in[i] ? MW'(-diff[i]) : MW'(diff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      l1_ff <= req_last_triangle;
      l2_ff <= l1_ff;
      l3_ff <= l2_ff;
      for (int i = 0; i < 3; i++) begin
         e1_ff[i] <= $signed({vb[i][COORD_BITS-1], vb[i]}) - $signed({va[i][COORD_BITS-1], va[i]});
         e2_ff[i] <= $signed({vc[i][COORD_BITS-1], vc[i]}) - $signed({vb[i][COORD_BITS-1], vb[i]});
         mag_ff[i] <= mag_in[i];
      end
      pa_ff[0] <= e1_ff[1] * e2_ff[2];
      pb_ff[0] <= e1_ff[2] * e2_ff[1];
      pa_ff[1] <= e1_ff[2] * e2_ff[0];
      pb_ff[1] <= e1_ff[0] * e2_ff[2];
      pa_ff[2] <= e1_ff[0] * e2_ff[1];
      pb_ff[2] <= e1_ff[1] * e2_ff[0];
      neg_ff <= neg_in;
   end

   assign push      = v3_ff;
   assign push_item = {l3_ff, ~|{mag_ff[2], mag_ff[1], mag_ff[0]}, neg_ff,
                       mag_ff[2], mag_ff[1], mag_ff[0]};

endmodule

>>> design/tfn_queue.sv
// Short queue that decouples the front end from the normalizing back end.
module tfn_queue #(
   parameter int WIDTH = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  logic [WIDTH-1:0]       push_item,
   input  logic                   pop,
   output logic [WIDTH-1:0]       pop_item,
   output tfn_pkg::tfn_qstat_type qstat
);
   import tfn_pkg::*;

   logic [WIDTH-1:0]  mem [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QLVL_W-1:0] level_ff, level_in;

   assign wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
   assign level_in  = level_ff + QLVL_W'(push) - QLVL_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
      if (push)
         mem[wr_ptr_ff] <= push_item;
   end

   assign pop_item    = mem[rd_ptr_ff];
   assign qstat.empty = level_ff == '0;
   assign qstat.level = level_ff;

endmodule

>>> design/tfn_back.sv
// Back end: scale, square sum, restoring divide, integer root and rounding per lane.
module tfn_back #(
   parameter int COORD_BITS       = 16,
   parameter int NORMAL_FRAC_BITS = 14
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  tfn_pkg::tfn_qstat_type               qstat,
   input  logic [3*(2*COORD_BITS+2)+4:0]        q_item,
   output logic                                 pop,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [NORMAL_FRAC_BITS+1:0]   rsp_normal_x,
   output logic signed [NORMAL_FRAC_BITS+1:0]   rsp_normal_y,
   output logic signed [NORMAL_FRAC_BITS+1:0]   rsp_normal_z,
   output logic                                 rsp_degenerate,
   output logic                                 rsp_last_out
);
   import tfn_pkg::*;

   localparam int MW  = 2 * COORD_BITS + 2;
   localparam int UW  = (MW > 31) ? 31 : MW;
   localparam int XW  = MW - UW;
   localparam int KW  = (XW > 0) ? $clog2(XW + 1) : 1;
   localparam int U2W = 2 * UW;
   localparam int SW  = U2W + 2;
   localparam int QB  = 2 * NORMAL_FRAC_BITS + 3;
   localparam int QE  = QB + 1;
   localparam int ISB = QE / 2;
   localparam int RW  = ISB + 2;
   localparam int OW  = NORMAL_FRAC_BITS + 2;

   typedef struct packed {
      logic       valid;
      logic       last;
      logic       deg;
      logic [2:0] neg;
   } side_type;

   logic     adv;
   side_type side_in;
   side_type side0_ff, side1_ff, side2_ff, side3_ff;
   side_type side_d_ff [QB+1];
   side_type side_r_ff [ISB+1];

   logic [MW-1:0]  m0_ff [3];
   logic [MW-1:0]  m1_ff [3];
   logic [KW-1:0]  k_ff, k_in;
   logic [UW-1:0]  u_ff [3];
   logic [U2W-1:0] u2_ff [3];
   logic [MW-1:0]  or_all;

   logic [SW-1:0]  drem_ff [3][QB+1];
   logic [QB-1:0]  dq_ff [3][QB+1];
   logic [SW-1:0]  ds_ff [QB+1];
   logic [2:0]     dlsb_ff;

   logic [QE-1:0]  rq_ff [3][ISB+1];
   logic [RW-1:0]  rrem_ff [3][ISB+1];
   logic [ISB-1:0] rroot_ff [3][ISB+1];

   logic              out_valid_ff;
   logic              out_deg_ff, out_last_ff;
   logic signed [OW-1:0] out_n_ff [3];
   logic signed [OW-1:0] out_n_in [3];

   assign adv = !(out_valid_ff && rsp_stall);
   assign pop = adv && !qstat.empty;

   assign side_in.valid = pop;
   assign side_in.last  = q_item[3*MW+4];
   assign side_in.deg   = q_item[3*MW+3];
   assign side_in.neg   = q_item[3*MW+2:3*MW];

   assign or_all = m0_ff[0] | m0_ff[1] | m0_ff[2];

   // shift that brings the largest magnitude under 2^UW
   generate
      if (XW > 0) begin : g_shift
         always_comb begin
            k_in = '0;
            for (int i = 0; i < XW; i++)
               if (or_all[UW+i])
                  k_in = KW'(i + 1);
         end
      end else begin : g_noshift
         assign k_in = '0;
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         side0_ff.valid <= 1'b0;
         side1_ff.valid <= 1'b0;
         side2_ff.valid <= 1'b0;
         side3_ff.valid <= 1'b0;
         side_d_ff[0].valid <= 1'b0;
      end else if (adv) begin
         side0_ff <= side_in;
         side1_ff <= side0_ff;
         side2_ff <= side1_ff;
         side3_ff <= side2_ff;
         side_d_ff[0] <= side3_ff;
      end
      if (adv) begin
         k_ff <= k_in;
         for (int l = 0; l < 3; l++) begin
            m0_ff[l] <= q_item[l*MW +: MW];
            m1_ff[l] <= m0_ff[l];
            u_ff[l]  <= UW'(m1_ff[l] >> k_ff);
            u2_ff[l] <= U2W'(u_ff[l] * u_ff[l]);
            drem_ff[l][0] <= SW'(u2_ff[l][U2W-1:1]);
            dq_ff[l][0]   <= '0;
            dlsb_ff[l]    <= u2_ff[l][0];
         end
         ds_ff[0] <= SW'(u2_ff[0]) + SW'(u2_ff[1]) + SW'(u2_ff[2]);
      end
   end

   // restoring divide: one quotient bit per stage
   genvar j;
   generate
      for (j = 1; j <= QB; j++) begin : g_div
         logic [SW:0]   cat_in [3];
         logic [SW:0]   sub_in [3];
         logic [2:0]    ge_in;
         always_comb begin
            for (int l = 0; l < 3; l++) begin
               cat_in[l] = {drem_ff[l][j-1], (j == 1) ? dlsb_ff[l] : 1'b0};
               sub_in[l] = cat_in[l] - {1'b0, ds_ff[j-1]};
               ge_in[l]  = cat_in[l] >= {1'b0, ds_ff[j-1]};
            end
         end
         always_ff @(posedge clock) begin
            if (reset)
               side_d_ff[j].valid <= 1'b0;
            else if (adv)
               side_d_ff[j] <= side_d_ff[j-1];
            if (adv) begin
               ds_ff[j] <= ds_ff[j-1];
               for (int l = 0; l < 3; l++) begin
                  drem_ff[l][j] <= ge_in[l] ? sub_in[l][SW-1:0] : cat_in[l][SW-1:0];
                  dq_ff[l][j]   <= {dq_ff[l][j-1][QB-2:0], ge_in[l]};
               end
            end
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset)
         side_r_ff[0].valid <= 1'b0;
      else if (adv)
         side_r_ff[0] <= side_d_ff[QB];
      if (adv) begin
         for (int l = 0; l < 3; l++) begin
            rq_ff[l][0]    <= {1'b0, dq_ff[l][QB]};
            rrem_ff[l][0]  <= '0;
            rroot_ff[l][0] <= '0;
         end
      end
   end

   // integer square root: two radicand bits per stage
   genvar i;
   generate
      for (i = 1; i <= ISB; i++) begin : g_root
         logic [RW+1:0] cat_in [3];
         logic [RW+1:0] trial_in [3];
         logic [RW+1:0] sub_in [3];
         logic [2:0]    ge_in;
         always_comb begin
            for (int l = 0; l < 3; l++) begin
               cat_in[l]   = {rrem_ff[l][i-1], rq_ff[l][i-1][QE-1-2*(i-1) -: 2]};
               trial_in[l] = {2'b00, rroot_ff[l][i-1], 2'b01};
               sub_in[l]   = cat_in[l] - trial_in[l];
               ge_in[l]    = cat_in[l] >= trial_in[l];
            end
         end
         always_ff @(posedge clock) begin
            if (reset)
               side_r_ff[i].valid <= 1'b0;
            else if (adv)
               side_r_ff[i] <= side_r_ff[i-1];
            if (adv) begin
               for (int l = 0; l < 3; l++) begin
                  rq_ff[l][i]    <= rq_ff[l][i-1];
                  rrem_ff[l][i]  <= ge_in[l] ? sub_in[l][RW-1:0] : cat_in[l][RW-1:0];
                  rroot_ff[l][i] <= {rroot_ff[l][i-1][ISB-2:0], ge_in[l]};
               end
            end
         end
      end
   endgenerate

   // round half up: r = (root + 1) / 2, then apply the sign; a degenerate result gives zero
   always_comb begin
      logic [ISB:0]  tp1;
      logic [OW-1:0] r;
      for (int l = 0; l < 3; l++) begin
         tp1 = {1'b0, rroot_ff[l][ISB]} + 1'b1;
         r   = OW'(tp1[ISB:1]);
         if (side_r_ff[ISB].deg)
            out_n_in[l] = '0;
         else if (side_r_ff[ISB].neg[l])
            out_n_in[l] = -$signed(r);
         else
            out_n_in[l] = $signed(r);
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         out_valid_ff <= 1'b0;
      else if (adv)
         out_valid_ff <= side_r_ff[ISB].valid;
      if (adv) begin
         out_deg_ff  <= side_r_ff[ISB].deg;
         out_last_ff <= side_r_ff[ISB].last;
         for (int l = 0; l < 3; l++)
            out_n_ff[l] <= out_n_in[l];
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_normal_x   = out_n_ff[0];
   assign rsp_normal_y   = out_n_ff[1];
   assign rsp_normal_z   = out_n_ff[2];
   assign rsp_degenerate = out_deg_ff;
   assign rsp_last_out   = out_last_ff;

endmodule

>>> design/triangle_face_normal.sv
// Path: with an empty queue, an accepted triangle passes through the front end (edge,
//   cross product and sign/magnitude registers), the queue, scale/square, divide, root and output.
// Throughput: one triangle per cycle; the queue holds enough transactions to cover the
//   front end so the input stalls only when the output is held.
// Reset: synchronous, clears all valid bits and queue pointers; payload is not cleared.
module triangle_face_normal #(
   parameter int COORD_BITS       = 16,
   parameter int NORMAL_FRAC_BITS = 14
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [COORD_BITS-1:0]       req_ax,
   input  logic signed [COORD_BITS-1:0]       req_ay,
   input  logic signed [COORD_BITS-1:0]       req_az,
   input  logic signed [COORD_BITS-1:0]       req_bx,
   input  logic signed [COORD_BITS-1:0]       req_by_coord,
   input  logic signed [COORD_BITS-1:0]       req_bz,
   input  logic signed [COORD_BITS-1:0]       req_cx,
   input  logic signed [COORD_BITS-1:0]       req_cy,
   input  logic signed [COORD_BITS-1:0]       req_cz,
   input  logic                               req_last_triangle,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [NORMAL_FRAC_BITS+1:0] rsp_normal_x,
   output logic signed [NORMAL_FRAC_BITS+1:0] rsp_normal_y,
   output logic signed [NORMAL_FRAC_BITS+1:0] rsp_normal_z,
   output logic                               rsp_degenerate,
   output logic                               rsp_last_out
);
   import tfn_pkg::*;

   localparam int IW = 3 * (2 * COORD_BITS + 2) + 5;

   tfn_qstat_type   qstat;
   logic            push, pop;
   logic [IW-1:0]   push_item, pop_item;

   tfn_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_ax            (req_ax),
      .req_ay            (req_ay),
      .req_az            (req_az),
      .req_bx            (req_bx),
      .req_by_coord      (req_by_coord),
      .req_bz            (req_bz),
      .req_cx            (req_cx),
      .req_cy            (req_cy),
      .req_cz            (req_cz),
      .req_last_triangle (req_last_triangle),
      .qstat             (qstat),
      .push              (push),
      .push_item         (push_item)
   );

   tfn_queue #(.WIDTH(IW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .qstat     (qstat)
   );

   tfn_back #(
      .COORD_BITS       (COORD_BITS),
      .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .qstat          (qstat),
      .q_item         (pop_item),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_normal_x   (rsp_normal_x),
      .rsp_normal_y   (rsp_normal_y),
      .rsp_normal_z   (rsp_normal_z),
      .rsp_degenerate (rsp_degenerate),
      .rsp_last_out   (rsp_last_out)
   );

endmodule

>>> design/tfn_checker.sv
// Port-level checks on the result channel, bound to the top level.
module tfn_checker #(
   parameter int NORMAL_FRAC_BITS = 14
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic signed [NORMAL_FRAC_BITS+1:0] rsp_normal_x,
   input logic signed [NORMAL_FRAC_BITS+1:0] rsp_normal_y,
   input logic signed [NORMAL_FRAC_BITS+1:0] rsp_normal_z,
   input logic                               rsp_degenerate,
   input logic                               rsp_last_out
);
   localparam logic signed [NORMAL_FRAC_BITS+1:0] ONE =
      (NORMAL_FRAC_BITS+2)'(1 << NORMAL_FRAC_BITS);

   a_deg_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |->
         rsp_normal_x == '0 && rsp_normal_y == '0 && rsp_normal_z == '0)
      else $error("degenerate result with nonzero normal");

   a_nondeg_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_degenerate |->
         rsp_normal_x != '0 || rsp_normal_y != '0 || rsp_normal_z != '0)
      else $error("unit normal rounded to zero");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         rsp_normal_x <= ONE && rsp_normal_x >= -ONE &&
         rsp_normal_y <= ONE && rsp_normal_y >= -ONE &&
         rsp_normal_z <= ONE && rsp_normal_z >= -ONE)
      else $error("normal component outside unit range");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_normal_x) &&
         $stable(rsp_normal_y) && $stable(rsp_normal_z) &&
         $stable(rsp_degenerate) && $stable(rsp_last_out))
      else $error("stalled transaction changed");

endmodule

bind triangle_face_normal tfn_checker #(.NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)) u_tfn_checker (.*);
